// ===== sv/q5sda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q5sda_pkg
// Types, constants and the fp16 widening function shared by the Q5 sub-block
// dot-accumulate core and its lane and floating-point units.
// ----------------------------------------------------------------------------
package q5sda_pkg;

  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned LANE_LEN   = 8;
  localparam int unsigned WEIGHT_W   = 5;
  localparam int unsigned LANE_SUM_W = 16;
  localparam int unsigned IDOT_W     = 18;
  localparam int unsigned SIG_W      = 51;

  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [30:0] F32_INF  = 31'h7F80_0000;

  typedef enum logic [1:0] {
    FP_MUL,
    FP_ADD,
    FP_CVT
  } fp_op_t;

  typedef struct packed {
    fp_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } fp_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LANES,
    ST_ISS_T1,
    ST_ISS_T3,
    ST_ISS_CVT,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_ISS_T2,
    ST_WAIT_C,
    ST_ISS_T4,
    ST_WAIT_D,
    ST_ISS_ACC,
    ST_WAIT_E,
    ST_FIN
  } core_state_t;

  // Exact fp16 to fp32 widening, subnormals normalised.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0]  expo;
    logic [9:0]  mant;
    logic [3:0]  top;
    logic [10:0] shifted;
    logic [7:0]  e;
    logic [31:0] res;
    expo    = h[14:10];
    mant    = h[9:0];
    top     = 4'd0;
    shifted = 11'd0;
    e       = 8'd0;
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) begin
        top = 4'(i);
      end
    end
    if (expo == 5'h1F) begin
      res = {h[15], 8'hFF, mant, 13'd0};
    end else if (expo != 5'd0) begin
      res = {h[15], 8'(expo) + 8'd112, mant, 13'd0};
    end else if (mant == 10'd0) begin
      res = {h[15], 31'd0};
    end else begin
      shifted = 11'(mant) << (4'd10 - top);
      e       = 8'd103 + 8'(top);
      res     = {h[15], e, shifted[9:0], 13'd0};
    end
    return res;
  endfunction

endpackage

// ===== sv/q5_subblock_dot_accumulate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q5_subblock_dot_accumulate_core
// Q5 sub-block dot product against int8 activations, accumulated per row in
// fp32 and emitted on the last sub-block of the row.
// ----------------------------------------------------------------------------
// Flow: a transfer runs the lanes, the integer merge and then six operations
//   that share the single two-stage fp32 unit, four of them in a dependent
//   chain; on the row's last sub-block the row value is then registered when
//   the output register is free. A new sub-block is taken only once idle.
// Reset: the row accumulator returns to +0.0 and the output register empties.
// ----------------------------------------------------------------------------
module q5_subblock_dot_accumulate_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] nibbles_first_half,
  input  logic [63:0] nibbles_second_half,
  input  logic [31:0] fifth_bits,
  input  logic [15:0] weight_scale,
  input  logic [15:0] weight_offset,
  input  logic [63:0] acts_0_7,
  input  logic [63:0] acts_8_15,
  input  logic [63:0] acts_16_23,
  input  logic [63:0] acts_24_31,
  input  logic [31:0] act_scale,
  input  logic [31:0] act_sum,
  input  logic        last_of_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] row_value
);

  localparam int unsigned NL = q5sda_pkg::NUM_LANES;
  localparam int unsigned LL = q5sda_pkg::LANE_LEN;

  q5sda_pkg::core_state_t state, state_next;

  logic in_xfer;
  assign in_stall = state != q5sda_pkg::ST_IDLE;
  assign in_xfer  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Weight and activation unpack. Element i < 16 takes the low nibble of byte
  // i%4 of nibble word i/4; element 16 + i takes the high nibble of the same
  // byte. The fifth bit sits at 8j+k for low nibbles and 8j+4+k for high ones.
  // --------------------------------------------------------------------------
  logic [127:0] nib_words;
  logic [255:0] act_bytes;
  assign nib_words = {nibbles_second_half, nibbles_first_half};
  assign act_bytes = {acts_24_31, acts_16_23, acts_8_15, acts_0_7};

  logic        [q5sda_pkg::WEIGHT_W-1:0] lane_w [NL][LL];
  logic signed [7:0]                     lane_a [NL][LL];
  logic signed [q5sda_pkg::LANE_SUM_W-1:0] lane_sum [NL];

  for (genvar g = 0; g < NL * LL; g++) begin : g_elem
    localparam int unsigned HI = (g >= 16) ? 1 : 0;
    localparam int unsigned J  = (g % 16) / 4;
    localparam int unsigned K  = g % 4;
    assign lane_w[g / LL][g % LL] = {fifth_bits[8 * J + 4 * HI + K],
                                     nib_words[32 * J + 8 * K + 4 * HI +: 4]};
    assign lane_a[g / LL][g % LL] = $signed(act_bytes[8 * g +: 8]);
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    q5sda_lane u_lane (
      .clk     (clk),
      .load    (in_xfer),
      .weights (lane_w[l]),
      .acts    (lane_a[l]),
      .sum     (lane_sum[l])
    );
  end

  // merging stage: combine the four lane sums into the exact integer dot
  logic signed [q5sda_pkg::IDOT_W-1:0] idot, idot_next;

  always_comb begin
    idot_next = '0;
    for (int l = 0; l < NL; l++) begin
      idot_next = idot_next + q5sda_pkg::IDOT_W'(lane_sum[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == q5sda_pkg::ST_LANES) begin
      idot <= idot_next;
    end
  end

  // --------------------------------------------------------------------------
  // Scalar operands, captured with the transfer
  // --------------------------------------------------------------------------
  logic [31:0] dsc, deff, dx, xsum;
  logic        last_q;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dsc    <= q5sda_pkg::widen_half(weight_scale);
      deff   <= q5sda_pkg::widen_half(weight_offset);
      dx     <= act_scale;
      xsum   <= act_sum;
      last_q <= last_of_row;
    end
  end

  // --------------------------------------------------------------------------
  // Shared fp32 unit and its intermediate terms
  // --------------------------------------------------------------------------
  logic               fpu_issue;
  q5sda_pkg::fp_req_t fpu_req;
  logic [31:0]        fpu_res;
  logic [31:0]        t1, t3, fidot, acc;
  logic               out_free;

  q5sda_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .issue (fpu_issue),
    .req   (fpu_req),
    .res   (fpu_res)
  );

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      q5sda_pkg::ST_IDLE:    if (in_xfer) state_next = q5sda_pkg::ST_LANES;
      q5sda_pkg::ST_LANES:   state_next = q5sda_pkg::ST_ISS_T1;
      q5sda_pkg::ST_ISS_T1:  state_next = q5sda_pkg::ST_ISS_T3;
      q5sda_pkg::ST_ISS_T3:  state_next = q5sda_pkg::ST_ISS_CVT;
      q5sda_pkg::ST_ISS_CVT: state_next = q5sda_pkg::ST_WAIT_A;
      q5sda_pkg::ST_WAIT_A:  state_next = q5sda_pkg::ST_WAIT_B;
      q5sda_pkg::ST_WAIT_B:  state_next = q5sda_pkg::ST_ISS_T2;
      q5sda_pkg::ST_ISS_T2:  state_next = q5sda_pkg::ST_WAIT_C;
      q5sda_pkg::ST_WAIT_C:  state_next = q5sda_pkg::ST_ISS_T4;
      q5sda_pkg::ST_ISS_T4:  state_next = q5sda_pkg::ST_WAIT_D;
      q5sda_pkg::ST_WAIT_D:  state_next = q5sda_pkg::ST_ISS_ACC;
      q5sda_pkg::ST_ISS_ACC: state_next = q5sda_pkg::ST_WAIT_E;
      q5sda_pkg::ST_WAIT_E:  state_next = q5sda_pkg::ST_FIN;
      q5sda_pkg::ST_FIN: begin
        // hold here while a finished row value still waits downstream
        if (!last_q || out_free) state_next = q5sda_pkg::ST_IDLE;
      end
      default: state_next = q5sda_pkg::ST_IDLE;
    endcase
  end

  // fp unit requests: t1 = dsc*dx, t3 = deff*xsum, fidot = float(idot),
  // t2 = t1*fidot, t4 = t2 - t3, acc = acc + t4
  always_comb begin
    fpu_issue = 1'b0;
    fpu_req   = '{op: q5sda_pkg::FP_MUL, a: dsc, b: dx};
    case (state)
      q5sda_pkg::ST_ISS_T1: begin
        fpu_issue = 1'b1;
        fpu_req   = '{op: q5sda_pkg::FP_MUL, a: dsc, b: dx};
      end
      q5sda_pkg::ST_ISS_T3: begin
        fpu_issue = 1'b1;
        fpu_req   = '{op: q5sda_pkg::FP_MUL, a: deff, b: xsum};
      end
      q5sda_pkg::ST_ISS_CVT: begin
        fpu_issue = 1'b1;
        fpu_req   = '{op: q5sda_pkg::FP_CVT, a: 32'(idot), b: 32'd0};
      end
      q5sda_pkg::ST_ISS_T2: begin
        fpu_issue = 1'b1;
        fpu_req   = '{op: q5sda_pkg::FP_MUL, a: t1, b: fidot};
      end
      q5sda_pkg::ST_ISS_T4: begin
        fpu_issue = 1'b1;
        fpu_req   = '{op: q5sda_pkg::FP_ADD, a: fpu_res, b: {~t3[31], t3[30:0]}};
      end
      q5sda_pkg::ST_ISS_ACC: begin
        fpu_issue = 1'b1;
        fpu_req   = '{op: q5sda_pkg::FP_ADD, a: acc, b: fpu_res};
      end
      default: begin
        fpu_issue = 1'b0;
      end
    endcase
  end

  // capture the first three results as they leave the fp unit
  always_ff @(posedge clk) begin
    case (state)
      q5sda_pkg::ST_ISS_CVT: t1    <= fpu_res;
      q5sda_pkg::ST_WAIT_A:  t3    <= fpu_res;
      q5sda_pkg::ST_WAIT_B:  fidot <= fpu_res;
      default: ;
    endcase
  end

  // state, accumulator and output register
  logic fin_emit, row_is_nan;
  assign fin_emit   = (state == q5sda_pkg::ST_FIN) && last_q && out_free;
  assign row_is_nan = (fpu_res[30:23] == 8'hFF) && (fpu_res[22:0] != 23'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= q5sda_pkg::ST_IDLE;
      acc       <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_emit) begin
        acc       <= 32'd0;
        out_valid <= 1'b1;
      end else begin
        if (state == q5sda_pkg::ST_FIN && !last_q) begin
          acc <= fpu_res;
        end
        // drop the result once its transfer completes
        if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_emit) begin
      row_value <= row_is_nan ? q5sda_pkg::F32_QNAN : fpu_res;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_xfer_starts_lanes: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == q5sda_pkg::ST_LANES)
    else $error("transfer did not start the lanes");

  a_mid_row_keeps_sum: assert property (@(posedge clk) disable iff (rst)
    (state == q5sda_pkg::ST_FIN && !last_q) |=> acc == $past(fpu_res))
    else $error("accumulator missed a mid-row update");

  a_emit_clears_acc: assert property (@(posedge clk) disable iff (rst)
    fin_emit |=> (out_valid && acc == 32'd0))
    else $error("row emit did not clear the accumulator");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == q5sda_pkg::ST_FIN && last_q && !out_free)
      |=> state == q5sda_pkg::ST_FIN)
    else $error("left finish state with output still occupied");

endmodule

// ===== sv/q5sda_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q5sda_lane
// One dot lane: eight 5-bit weights times eight signed bytes, summed and
// registered.
// ----------------------------------------------------------------------------
module q5sda_lane (
  input  logic                                        clk,
  input  logic                                        load,
  input  logic        [q5sda_pkg::WEIGHT_W-1:0]       weights [q5sda_pkg::LANE_LEN],
  input  logic signed [7:0]                           acts    [q5sda_pkg::LANE_LEN],
  output logic signed [q5sda_pkg::LANE_SUM_W-1:0]     sum
);

  logic signed [q5sda_pkg::LANE_SUM_W-1:0] sum_next;

  always_comb begin
    logic signed [13:0] prod;
    sum_next = '0;
    for (int i = 0; i < q5sda_pkg::LANE_LEN; i++) begin
      prod     = 14'($signed({1'b0, weights[i]}) * acts[i]);
      sum_next = sum_next + q5sda_pkg::LANE_SUM_W'(prod);
    end
  end

  // hold between loads
  always_ff @(posedge clk) begin
    if (load) begin
      sum <= sum_next;
    end
  end

endmodule

// ===== sv/q5sda_fpu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q5sda_fpu
// Two-stage fp32 unit: multiply, add and int-to-float, round to nearest even
// with subnormals. Stage one forms an exact-enough significand, stage two
// normalises, rounds and packs.
// ----------------------------------------------------------------------------
module q5sda_fpu (
  input  logic                clk,
  input  logic                rst,
  input  logic                issue,
  input  q5sda_pkg::fp_req_t  req,
  output logic [31:0]         res
);

  localparam int unsigned SW = q5sda_pkg::SIG_W;

  logic                 s1_valid;
  logic                 s1_special;
  logic [31:0]          s1_spec_val;
  logic                 s1_sign;
  logic [SW-1:0]        s1_sig;
  logic signed [11:0]   s1_exp;

  logic                 special_next;
  logic [31:0]          spec_val_next;
  logic                 sign_next;
  logic [SW-1:0]        sig_next;
  logic signed [11:0]   exp_next;

  // operand decode and stage-one arithmetic
  always_comb begin
    logic [7:0]   ea, eb, eea, eeb, ebig, esm, d;
    logic [23:0]  ma, mb, mbig, msm;
    logic         sa, sb, sbig, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [99:0]  al;
    logic [SW-1:0] big, small_v;
    logic         sticky;
    logic [31:0]  mag;
    ea     = req.a[30:23];
    eb     = req.b[30:23];
    sa     = req.a[31];
    sb     = req.b[31];
    ma     = {ea != 8'd0, req.a[22:0]};
    mb     = {eb != 8'd0, req.b[22:0]};
    eea    = (ea == 8'd0) ? 8'd1 : ea;
    eeb    = (eb == 8'd0) ? 8'd1 : eb;
    a_nan  = (ea == 8'hFF) && (req.a[22:0] != 23'd0);
    b_nan  = (eb == 8'hFF) && (req.b[22:0] != 23'd0);
    a_inf  = (ea == 8'hFF) && (req.a[22:0] == 23'd0);
    b_inf  = (eb == 8'hFF) && (req.b[22:0] == 23'd0);
    a_zero = req.a[30:0] == 31'd0;
    b_zero = req.b[30:0] == 31'd0;
    ebig = 8'd0; esm = 8'd0; d = 8'd0; mbig = 24'd0; msm = 24'd0; sbig = 1'b0;
    al = '0; big = '0; small_v = '0; sticky = 1'b0; mag = 32'd0;

    special_next  = 1'b0;
    spec_val_next = q5sda_pkg::F32_QNAN;
    sign_next     = 1'b0;
    sig_next      = '0;
    exp_next      = '0;

    case (req.op)
      q5sda_pkg::FP_MUL: begin
        sign_next = sa ^ sb;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
          special_next = 1'b1;
        end else if (a_inf || b_inf) begin
          special_next  = 1'b1;
          spec_val_next = {sa ^ sb, q5sda_pkg::F32_INF};
        end
        sig_next = SW'(ma * mb);
        exp_next = $signed(12'(eea)) + $signed(12'(eeb)) - 12'sd300;
      end
      q5sda_pkg::FP_ADD: begin
        if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
          special_next = 1'b1;
        end else if (a_inf) begin
          special_next  = 1'b1;
          spec_val_next = req.a;
        end else if (b_inf) begin
          special_next  = 1'b1;
          spec_val_next = req.b;
        end
        if (req.a[30:0] >= req.b[30:0]) begin
          ebig = eea; esm = eeb; mbig = ma; msm = mb; sbig = sa;
        end else begin
          ebig = eeb; esm = eea; mbig = mb; msm = ma; sbig = sb;
        end
        d = ebig - esm;
        // align the smaller operand, fold shifted-out bits into a sticky bit
        if (d > 8'd60) begin
          al = '0;
          sticky = msm != 24'd0;
        end else begin
          al = {msm, 26'd0, 50'd0} >> d;
          sticky = al[49:0] != 50'd0;
        end
        big     = SW'({mbig, 26'd0});
        small_v = SW'(al[99:50]) | SW'(sticky);
        sig_next = (sa == sb) ? big + small_v : big - small_v;
        exp_next = $signed(12'(ebig)) - 12'sd176;
        sign_next = (sig_next == '0) ? (sa & sb) : sbig;
      end
      q5sda_pkg::FP_CVT: begin
        sign_next = req.a[31];
        mag       = req.a[31] ? (32'd0 - req.a) : req.a;
        sig_next  = SW'(mag);
        exp_next  = '0;
      end
      default: begin
        special_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_special  <= special_next;
      s1_spec_val <= spec_val_next;
      s1_sign     <= sign_next;
      s1_sig      <= sig_next;
      s1_exp      <= exp_next;
    end
  end

  // normalise, round to nearest even, pack
  logic [31:0] res_next;

  always_comb begin
    logic [5:0]          lead;
    logic signed [11:0]  lsb_exp, sh;
    logic [2*SW-1:0]     t;
    logic [SW-1:0]       q;
    logic                rb, st;
    logic [24:0]         qr;
    logic [40:0]         u;
    lead = 6'd0;
    for (int i = 0; i < SW; i++) begin
      if (s1_sig[i]) begin
        lead = 6'(i);
      end
    end
    lsb_exp = s1_exp + $signed(12'(lead)) - 12'sd23;
    if (lsb_exp < -12'sd149) begin
      lsb_exp = -12'sd149;
    end
    sh = lsb_exp - s1_exp;
    t  = '0;
    if (sh <= 12'sd0) begin
      q  = s1_sig << 6'(-sh);
      rb = 1'b0;
      st = 1'b0;
    end else if (sh > 12'sd51) begin
      q  = '0;
      rb = 1'b0;
      st = s1_sig != '0;
    end else begin
      t  = {s1_sig, {SW{1'b0}}} >> sh[5:0];
      q  = t[2*SW-1:SW];
      rb = t[SW-1];
      st = t[SW-2:0] != '0;
    end
    qr = 25'(q) + 25'(rb & (st | q[0]));
    u  = (41'(lsb_exp + 12'sd149) << 23) + 41'(qr);
    if (s1_special) begin
      res_next = s1_spec_val;
    end else if (s1_sig == '0) begin
      res_next = {s1_sign, 31'd0};
    end else if (u >= 41'(q5sda_pkg::F32_INF)) begin
      res_next = {s1_sign, q5sda_pkg::F32_INF};
    end else begin
      res_next = {s1_sign, u[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      res <= res_next;
    end
  end

endmodule
